>>> sv/vsar_pkg.sv
// Package for the scroll address and register unit: function and register codes,
// item, result and architectural state types, and the fixed bit masks.
// It depends on nothing; vsar_step and the top level refer to it by scoped names.
package vsar_pkg;

    typedef enum logic [3:0] {
        FUNC_REG_WRITE  = 4'd0,
        FUNC_REG_READ   = 4'd1,
        FUNC_COARSE_X   = 4'd2,
        FUNC_FINE_Y     = 4'd3,
        FUNC_COPY_HORIZ = 4'd4,
        FUNC_COPY_VERT  = 4'd5,
        FUNC_SET_VBLANK = 4'd6,
        FUNC_CLR_FLAGS  = 4'd7,
        FUNC_SPRITE0    = 4'd8,
        FUNC_OVERFLOW   = 4'd9
    } func_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_t;

    // Bit positions of the status flags.
    localparam int unsigned FLAG_VBLANK   = 2;
    localparam int unsigned FLAG_SPRITE0  = 1;
    localparam int unsigned FLAG_OVERFLOW = 0;

    // Control byte bits.
    localparam int unsigned CTRL_NMI_EN  = 7;
    localparam int unsigned CTRL_INC_32  = 2;

    // Address masks for the horizontal and vertical copies.
    localparam logic [14:0] MASK_HORIZ = 15'h041F;
    localparam logic [14:0] MASK_VERT  = 15'h7BE0;

    // Coarse Y row at which the fine-Y step wraps into the next nametable.
    localparam logic [4:0] ROW_LAST_VISIBLE = 5'd29;
    localparam logic [4:0] ROW_MAX          = 5'd31;
    localparam logic [4:0] COARSE_X_MAX     = 5'd31;

    typedef struct packed {
        logic [3:0] func;
        logic [2:0] reg_sel;
        logic [7:0] wdata;
        logic [7:0] mem_data;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [13:0] access_addr;
        logic        mem_write;
        logic        mem_read;
        logic [14:0] cur_addr;
        logic [2:0]  fine_x_out;
        logic        nmi_pulse;
    } result_t;

    typedef struct packed {
        logic [14:0] cur_vaddr;
        logic [14:0] temp_vaddr;
        logic [2:0]  fine_x;
        logic        write_toggle;
        logic [7:0]  control_byte;
        logic [2:0]  status_flags;
        logic [7:0]  read_buffer;
        logic [7:0]  open_bus;
    } state_t;

endpackage

>>> sv/vsar_step.sv
// Combinational update of the scroll address and register state for one word.
// Depends on vsar_pkg for the codes, masks and the item, result and state types.
module vsar_step
(
    input  vsar_pkg::item_t   item,
    input  vsar_pkg::state_t  state,
    output vsar_pkg::state_t  state_next,
    output vsar_pkg::result_t result
);

    logic [14:0] inc_addr;
    logic [14:0] fine_y_addr;
    logic [4:0]  row;

    // Data port step: 32 walks down a column, 1 along a row.
    assign inc_addr = state.cur_vaddr
                    + (state.control_byte[vsar_pkg::CTRL_INC_32] ? 15'd32 : 15'd1);

    // Fine Y counts inside a tile; on overflow the coarse row advances, and
    // row 29 wraps to the next nametable vertically, row 31 wraps without
    // switching nametable, and row 30 steps on to row 31.
    always_comb
    begin
        fine_y_addr = state.cur_vaddr;
        row         = state.cur_vaddr[9:5];
        if (state.cur_vaddr[14:12] != 3'd7)
        begin
            fine_y_addr[14:12] = state.cur_vaddr[14:12] + 3'd1;
        end
        else
        begin
            fine_y_addr[14:12] = 3'd0;
            if (row == vsar_pkg::ROW_LAST_VISIBLE)
            begin
                fine_y_addr[9:5] = 5'd0;
                fine_y_addr[11]  = ~state.cur_vaddr[11];
            end
            else if (row == vsar_pkg::ROW_MAX)
            begin
                fine_y_addr[9:5] = 5'd0;
            end
            else
            begin
                fine_y_addr[9:5] = row + 5'd1;
            end
        end
    end

    always_comb
    begin
        state_next       = state;
        result.mem_write = 1'b0;
        result.mem_read  = 1'b0;
        result.nmi_pulse = 1'b0;

        case (vsar_pkg::func_t'(item.func))
            vsar_pkg::FUNC_REG_WRITE:
            begin
                case (vsar_pkg::reg_t'(item.reg_sel))
                    vsar_pkg::REG_CTRL:
                    begin
                        state_next.temp_vaddr[11:10] = item.wdata[1:0];
                        state_next.control_byte      = item.wdata;
                    end
                    vsar_pkg::REG_SCROLL:
                    begin
                        if (!state.write_toggle)
                        begin
                            state_next.temp_vaddr[4:0] = item.wdata[7:3];
                            state_next.fine_x          = item.wdata[2:0];
                        end
                        else
                        begin
                            state_next.temp_vaddr[14:12] = item.wdata[2:0];
                            state_next.temp_vaddr[9:5]   = item.wdata[7:3];
                        end
                        state_next.write_toggle = ~state.write_toggle;
                    end
                    vsar_pkg::REG_ADDR:
                    begin
                        if (!state.write_toggle)
                        begin
                            state_next.temp_vaddr[14]   = 1'b0;
                            state_next.temp_vaddr[13:8] = item.wdata[5:0];
                        end
                        else
                        begin
                            state_next.temp_vaddr[7:0] = item.wdata;
                            state_next.cur_vaddr       = {state.temp_vaddr[14:8], item.wdata};
                        end
                        state_next.write_toggle = ~state.write_toggle;
                    end
                    vsar_pkg::REG_DATA:
                    begin
                        result.mem_write     = 1'b1;
                        state_next.cur_vaddr = inc_addr;
                    end
                    default:
                    begin
                        // Mask, status and OAM writes have no effect here.
                    end
                endcase
            end
            vsar_pkg::FUNC_REG_READ:
            begin
                case (vsar_pkg::reg_t'(item.reg_sel))
                    vsar_pkg::REG_DATA:
                    begin
                        state_next.open_bus    = state.read_buffer;
                        state_next.read_buffer = item.mem_data;
                        result.mem_read        = 1'b1;
                        state_next.cur_vaddr   = inc_addr;
                    end
                    vsar_pkg::REG_STATUS:
                    begin
                        state_next.open_bus[7:5] = state.status_flags;
                        state_next.status_flags[vsar_pkg::FLAG_VBLANK] = 1'b0;
                        state_next.write_toggle  = 1'b0;
                    end
                    default:
                    begin
                        // Write-only registers read back the open-bus latch.
                    end
                endcase
            end
            vsar_pkg::FUNC_COARSE_X:
            begin
                if (state.cur_vaddr[4:0] == vsar_pkg::COARSE_X_MAX)
                begin
                    state_next.cur_vaddr[4:0] = 5'd0;
                    state_next.cur_vaddr[10]  = ~state.cur_vaddr[10];
                end
                else
                begin
                    state_next.cur_vaddr = state.cur_vaddr + 15'd1;
                end
            end
            vsar_pkg::FUNC_FINE_Y:
            begin
                state_next.cur_vaddr = fine_y_addr;
            end
            vsar_pkg::FUNC_COPY_HORIZ:
            begin
                state_next.cur_vaddr = (state.cur_vaddr & ~vsar_pkg::MASK_HORIZ)
                                     | (state.temp_vaddr & vsar_pkg::MASK_HORIZ);
            end
            vsar_pkg::FUNC_COPY_VERT:
            begin
                state_next.cur_vaddr = (state.cur_vaddr & ~vsar_pkg::MASK_VERT)
                                     | (state.temp_vaddr & vsar_pkg::MASK_VERT);
            end
            vsar_pkg::FUNC_SET_VBLANK:
            begin
                state_next.status_flags[vsar_pkg::FLAG_VBLANK] = 1'b1;
                result.nmi_pulse = state.control_byte[vsar_pkg::CTRL_NMI_EN];
            end
            vsar_pkg::FUNC_CLR_FLAGS:
            begin
                state_next.status_flags = 3'd0;
            end
            vsar_pkg::FUNC_SPRITE0:
            begin
                state_next.status_flags[vsar_pkg::FLAG_SPRITE0] = 1'b1;
            end
            vsar_pkg::FUNC_OVERFLOW:
            begin
                state_next.status_flags[vsar_pkg::FLAG_OVERFLOW] = 1'b1;
            end
            default:
            begin
                // Unused function codes leave everything as it is.
            end
        endcase

        result.read_data   = state_next.open_bus;
        result.access_addr = state.cur_vaddr[13:0];
        result.cur_addr    = state_next.cur_vaddr;
        result.fine_x_out  = state_next.fine_x;
    end

endmodule

>>> sv/video_scroll_address_registers_unit.sv
// Top level of the scroll address and register unit: input register, state
// registers, result register and handshake. Depends on vsar_pkg and vsar_step.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   func, reg_sel, wdata, mem_data
//   result    out        out_valid / out_stall read_data, access_addr, mem_write,
//                                              mem_read, cur_addr, fine_x_out,
//                                              nmi_pulse
//
// Every accepted word gives exactly one result word. The word passes from the
// input register through vsar_step into the result register, where it is
// offered at the output, and a new word may be accepted in every cycle while
// the output side is not stalled. The state update is a single short pass through
// vsar_step, taken from the input register into the result register.
// Reset (rst_n low, asynchronous) clears all state, including both addresses,
// fine X, the write toggle, the flags and the read buffer, and empties both
// stages. A stall on the result side holds the result register; the input
// register keeps taking a word until it too is full.
module video_scroll_address_registers_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  func,
    input  logic [2:0]  reg_sel,
    input  logic [7:0]  wdata,
    input  logic [7:0]  mem_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [13:0] access_addr,
    output logic        mem_write,
    output logic        mem_read,
    output logic [14:0] cur_addr,
    output logic [2:0]  fine_x_out,
    output logic        nmi_pulse
);

    // Input stage: holds one word until the result register can take its result.
    logic              item_valid_reg;
    vsar_pkg::item_t   item_reg;

    // Architectural state, updated once for each word that moves forward.
    vsar_pkg::state_t  state_reg;
    vsar_pkg::state_t  state_next;

    // Result stage.
    logic              res_valid_reg;
    vsar_pkg::result_t res_reg;
    vsar_pkg::result_t res_next;

    logic              advance;
    logic              in_take;

    // The result register is free when empty or being emptied this cycle.
    assign advance  = item_valid_reg && (!res_valid_reg || !out_stall);
    // The input register is free when empty or when its word moves forward.
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    vsar_step u_step
    (
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.func     <= func;
            item_reg.reg_sel  <= reg_sel;
            item_reg.wdata    <= wdata;
            item_reg.mem_data <= mem_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign read_data   = res_reg.read_data;
    assign access_addr = res_reg.access_addr;
    assign mem_write   = res_reg.mem_write;
    assign mem_read    = res_reg.mem_read;
    assign cur_addr    = res_reg.cur_addr;
    assign fine_x_out  = res_reg.fine_x_out;
    assign nmi_pulse   = res_reg.nmi_pulse;

endmodule

>>> sv/vsar_checker.sv
// Port-level checks for the scroll address and register unit, and the bind
// that attaches them to the top level. Depends only on the top level's ports.
module vsar_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [13:0] access_addr,
    input logic        mem_write,
    input logic        mem_read,
    input logic [14:0] cur_addr,
    input logic        nmi_pulse
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cur_addr))
        else $error("stalled result word changed");

    // A word makes at most one memory access.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(mem_write && mem_read))
        else $error("memory read and write in one word");

    // A data-port access steps the address by 1 or by 32.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mem_write || mem_read) |->
            (14'(cur_addr[13:0] - access_addr) == 14'd1) ||
            (14'(cur_addr[13:0] - access_addr) == 14'd32))
        else $error("data access increment wrong");

    // A vblank interrupt pulse never comes with a memory access.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && nmi_pulse |-> !mem_write && !mem_read)
        else $error("interrupt pulse on a data access");

endmodule

bind video_scroll_address_registers_unit vsar_checker u_vsar_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .access_addr (access_addr),
    .mem_write   (mem_write),
    .mem_read    (mem_read),
    .cur_addr    (cur_addr),
    .nmi_pulse   (nmi_pulse)
);
